// ===== rtl/ate_pkg.sv =====
package ate_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int SLOT_W = 6;
  localparam int STAT_W = 2;
  localparam int LCNT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND  = 3'd0,
    KIND_EDIT    = 3'd1,
    KIND_DELETE  = 3'd2,
    KIND_SEARCH  = 3'd3,
    KIND_DEL_ALL = 3'd4,
    KIND_READ    = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT,
    CELL_ROTATE,
    CELL_SWAP_EVEN,
    CELL_SWAP_ODD,
    CELL_CLEAN
  } cell_op_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic                     dead;
  } cell_t;

  typedef struct packed {
    cell_op_e                 op;
    logic [IDX_W-1:0]         slot;
    logic signed [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

// ===== rtl/ate_cell.sv =====
module ate_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ate_pkg::IDX_W-1:0] idx_i,
  input  ate_pkg::cell_cmd_t       cmd_i,
  input  ate_pkg::cell_t           up_i,
  input  ate_pkg::cell_t           dn_i,
  output ate_pkg::cell_t           cell_o
);

  ate_pkg::cell_t cell_q, cell_d;
  logic           is_top;
  logic           is_lower;

  assign is_top   = (idx_i == ate_pkg::IDX_W'(ate_pkg::DEPTH - 1));
  // lower member of its pair in this sort phase
  assign is_lower = (cmd_i.op == ate_pkg::CELL_SWAP_EVEN) ? !idx_i[0] : idx_i[0];

  always_comb begin
    cell_d = cell_q;
    unique case (cmd_i.op)
      ate_pkg::CELL_WRITE: begin
        if (idx_i == cmd_i.slot) cell_d.word = cmd_i.word;
      end
      ate_pkg::CELL_SHIFT: begin
        if (idx_i >= cmd_i.slot) begin
          cell_d.word = is_top ? '0 : up_i.word;
          cell_d.dead = 1'b0;
        end
      end
      ate_pkg::CELL_ROTATE: cell_d = up_i;
      ate_pkg::CELL_SWAP_EVEN, ate_pkg::CELL_SWAP_ODD: begin
        // move dead words up past live ones
        if (is_lower) begin
          if (cell_q.dead && !up_i.dead) cell_d = up_i;
        end else begin
          if (dn_i.dead && !cell_q.dead) cell_d = dn_i;
        end
      end
      ate_pkg::CELL_CLEAN: begin
        if (cell_q.dead) cell_d = '0;
      end
      default: cell_d = cell_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/ate_ctrl.sv =====
module ate_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [ate_pkg::KIND_W-1:0]        kind_i,
  input  logic [ate_pkg::SLOT_W-1:0]        slot_i,
  input  logic signed [ate_pkg::WORD_W-1:0] word_i,
  input  ate_pkg::cell_t                    head_i,
  output ate_pkg::cell_cmd_t                cmd_o,
  output ate_pkg::cell_t                    feed_o,
  output logic                              done_o,
  output logic [ate_pkg::STAT_W-1:0]        status_o,
  output logic                              found_o,
  output logic [ate_pkg::SLOT_W-1:0]        found_slot_o,
  output logic signed [ate_pkg::WORD_W-1:0] read_word_o,
  output logic [ate_pkg::LCNT_W-1:0]        live_count_o
);

  typedef enum logic [1:0] {S_IDLE, S_ROTATE, S_SORT, S_CLEAN} state_e;

  localparam logic [ate_pkg::IDX_W-1:0] LAST = ate_pkg::IDX_W'(ate_pkg::DEPTH - 1);

  state_e                            state_q;
  logic [ate_pkg::IDX_W-1:0]         i_q;
  logic [ate_pkg::CNT_W-1:0]         count_q;
  logic [ate_pkg::CNT_W-1:0]         ndead_q;
  ate_pkg::kind_e                    kind_q;
  logic signed [ate_pkg::WORD_W-1:0] key_q;
  logic [ate_pkg::IDX_W-1:0]         slot_q;
  logic                              done_q;
  ate_pkg::status_e                  status_q;
  logic                              found_q;
  logic [ate_pkg::IDX_W-1:0]         fslot_q;
  logic signed [ate_pkg::WORD_W-1:0] rword_q;

  ate_pkg::kind_e kind_in;
  logic           slot_ok;
  logic           full;
  logic           live_now;
  logic           hit;
  logic           mark;

  assign kind_in  = ate_pkg::kind_e'(kind_i);
  assign slot_ok  = int'(slot_i) < int'(count_q);
  assign full     = int'(count_q) >= ate_pkg::DEPTH;
  assign live_now = int'(i_q) < int'(count_q);
  assign hit      = (head_i.word == key_q);
  assign mark     = (kind_q == ate_pkg::KIND_DEL_ALL) && live_now && hit;

  always_comb begin
    cmd_o.op   = ate_pkg::CELL_HOLD;
    cmd_o.slot = ate_pkg::IDX_W'(slot_i);
    cmd_o.word = word_i;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (kind_in)
            ate_pkg::KIND_APPEND: begin
              cmd_o.slot = ate_pkg::IDX_W'(count_q);
              if (!full) cmd_o.op = ate_pkg::CELL_WRITE;
            end
            ate_pkg::KIND_EDIT: begin
              if (slot_ok) cmd_o.op = ate_pkg::CELL_WRITE;
            end
            ate_pkg::KIND_DELETE: begin
              if (slot_ok) cmd_o.op = ate_pkg::CELL_SHIFT;
            end
            default: cmd_o.op = ate_pkg::CELL_HOLD;
          endcase
        end
      end
      S_ROTATE: cmd_o.op = ate_pkg::CELL_ROTATE;
      S_SORT:   cmd_o.op = i_q[0] ? ate_pkg::CELL_SWAP_ODD : ate_pkg::CELL_SWAP_EVEN;
      S_CLEAN:  cmd_o.op = ate_pkg::CELL_CLEAN;
      default:  cmd_o.op = ate_pkg::CELL_HOLD;
    endcase
  end

  // top cell input: the head word coming around; a dead top edge while sorting
  assign feed_o.word = head_i.word;
  assign feed_o.dead = (state_q == S_SORT) ? 1'b1 : mark;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      count_q  <= '0;
      ndead_q  <= '0;
      kind_q   <= ate_pkg::KIND_APPEND;
      key_q    <= '0;
      slot_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ate_pkg::ST_OK;
      found_q  <= 1'b0;
      fslot_q  <= '0;
      rword_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            status_q <= ate_pkg::ST_OK;
            found_q  <= 1'b0;
            fslot_q  <= '0;
            rword_q  <= '0;
            kind_q   <= kind_in;
            key_q    <= word_i;
            slot_q   <= ate_pkg::IDX_W'(slot_i);
            i_q      <= '0;
            ndead_q  <= '0;
            unique case (kind_in)
              ate_pkg::KIND_APPEND: begin
                if (full) status_q <= ate_pkg::ST_FULL;
                else      count_q  <= count_q + 1'b1;
                done_q <= 1'b1;
              end
              ate_pkg::KIND_EDIT: begin
                if (!slot_ok) status_q <= ate_pkg::ST_RANGE;
                done_q <= 1'b1;
              end
              ate_pkg::KIND_DELETE: begin
                if (!slot_ok) status_q <= ate_pkg::ST_RANGE;
                else          count_q  <= count_q - 1'b1;
                done_q <= 1'b1;
              end
              ate_pkg::KIND_SEARCH, ate_pkg::KIND_DEL_ALL: state_q <= S_ROTATE;
              ate_pkg::KIND_READ: begin
                if (!slot_ok) begin
                  status_q <= ate_pkg::ST_RANGE;
                  done_q   <= 1'b1;
                end else begin
                  state_q <= S_ROTATE;
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        S_ROTATE: begin
          i_q <= i_q + 1'b1;
          if (kind_q == ate_pkg::KIND_READ && i_q == slot_q) rword_q <= head_i.word;
          if (kind_q == ate_pkg::KIND_SEARCH && !found_q && live_now && hit) begin
            found_q <= 1'b1;
            fslot_q <= i_q;
          end
          if (mark) ndead_q <= ndead_q + 1'b1;
          if (i_q == LAST) begin
            i_q <= '0;
            if (kind_q == ate_pkg::KIND_DEL_ALL) begin
              state_q <= S_SORT;
            end else begin
              state_q <= S_IDLE;
              done_q  <= 1'b1;
            end
          end
        end
        S_SORT: begin
          i_q <= i_q + 1'b1;
          if (i_q == LAST) begin
            i_q     <= '0;
            state_q <= S_CLEAN;
          end
        end
        S_CLEAN: begin
          count_q <= count_q - ndead_q;
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign found_o      = found_q;
  assign found_slot_o = ate_pkg::SLOT_W'(fslot_q);
  assign read_word_o  = rword_q;
  assign live_count_o = ate_pkg::LCNT_W'(count_q);

endmodule

// ===== rtl/array_table_editor_unit.sv =====
// Operations: append, edit, delete at index and any rejected request give the
//   result in the cycle after accept; read and search take one full turn of
//   the cell ring; delete-all takes a ring turn, the sort phases and a clean step.
// Flow: one item at a time, taken at the edge that ends the strobe
//   cycle; no new item is taken while busy.
// Reset: asynchronous, active low; clears every cell and the count at once.
// Results are strobed for one cycle on done_o; the receiver cannot stall.
module array_table_editor_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [ate_pkg::KIND_W-1:0]        kind_i,
  input  logic [ate_pkg::SLOT_W-1:0]        slot_i,
  input  logic signed [ate_pkg::WORD_W-1:0] word_i,
  output logic                              done_o,
  output logic [ate_pkg::STAT_W-1:0]        status_o,
  output logic                              found_o,
  output logic [ate_pkg::SLOT_W-1:0]        found_slot_o,
  output logic signed [ate_pkg::WORD_W-1:0] read_word_o,
  output logic [ate_pkg::LCNT_W-1:0]        live_count_o
);

  // The table lives in a row of DEPTH cells, cell k holding slot k.
  // Single-slot writes and the delete shift act on every cell at once,
  // each cell comparing its own index with the broadcast slot.
  // Read and search rotate the row once: the word in cell 0 goes around to
  // the top cell, so slot i is at the head while the turn counter reads i.
  // Delete-all marks matches during a turn, then runs DEPTH odd-even
  // transposition phases that push dead words past live ones without
  // reordering the survivors, and a last clean step zeroes the dead words.

  ate_pkg::cell_t     chain [ate_pkg::DEPTH];
  ate_pkg::cell_t     up_w  [ate_pkg::DEPTH];
  ate_pkg::cell_t     dn_w  [ate_pkg::DEPTH];
  ate_pkg::cell_cmd_t cmd;
  ate_pkg::cell_t     feed;

  ate_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .slot_i       (slot_i),
    .word_i       (word_i),
    .head_i       (chain[0]),
    .cmd_o        (cmd),
    .feed_o       (feed),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .found_slot_o (found_slot_o),
    .read_word_o  (read_word_o),
    .live_count_o (live_count_o)
  );

  for (genvar k = 0; k < ate_pkg::DEPTH; k++) begin : g_cell
    // top cell takes the controller feed; cell 0 sees an idle neighbor below
    if (k == ate_pkg::DEPTH - 1) begin : g_top
      assign up_w[k] = feed;
    end else begin : g_mid
      assign up_w[k] = chain[k+1];
    end
    if (k == 0) begin : g_bot
      assign dn_w[k] = '0;
    end else begin : g_dn
      assign dn_w[k] = chain[k-1];
    end

    ate_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (ate_pkg::IDX_W'(k)),
      .cmd_i  (cmd),
      .up_i   (up_w[k]),
      .dn_i   (dn_w[k]),
      .cell_o (chain[k])
    );
  end

  // never more live words than cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(live_count_o) <= ate_pkg::DEPTH)
    else $error("live count above depth");

  // a result is shown only with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // single-slot writes finish in the next cycle
  a_fast_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == ate_pkg::KIND_APPEND || kind_i == ate_pkg::KIND_EDIT))
    |=> (done_o && !busy))
    else $error("append or edit did not finish in one cycle");

  // search always walks the ring
  a_search_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == ate_pkg::KIND_SEARCH) |=> (busy && !done_o))
    else $error("search did not start a ring turn");

endmodule
